[src/srch_pkg.sv]
// ----------------------------------------------------------------------------
// srch_pkg
// shared widths, codes and types of the equal-range search unit
// ----------------------------------------------------------------------------
package srch_pkg;

   // item field widths
   localparam int VAL_W = 32;
   localparam int IDX_W = 10;

   // action codes of an input item
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // bisection flavors
   localparam logic MODE_BELOW = 1'b0;   // last position below the target
   localparam logic MODE_ABOVE = 1'b1;   // first position above the target

   // status of one bisection engine
   typedef struct packed {
      logic done;    // search finished, border stable
      logic hit;     // border was set at least once
   } srch_stat_type;

endpackage

[src/srch_mem.sv]
// ----------------------------------------------------------------------------
// srch_mem
// table storage: one write port, two registered read ports
// ----------------------------------------------------------------------------
module srch_mem #(
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [$clog2(DEPTH)-1:0]               wr_addr,
   input  logic signed [srch_pkg::VAL_W-1:0]      wr_data,
   input  logic [$clog2(DEPTH)-1:0]               rd_addr_a,
   output logic signed [srch_pkg::VAL_W-1:0]      rd_data_a,
   input  logic [$clog2(DEPTH)-1:0]               rd_addr_b,
   output logic signed [srch_pkg::VAL_W-1:0]      rd_data_b
);
   import srch_pkg::*;

   logic signed [VAL_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

[src/srch_bisect.sv]
// ----------------------------------------------------------------------------
// srch_bisect
// one midpoint bisection over the table, each step a read phase then a compare phase
// ----------------------------------------------------------------------------
module srch_bisect #(
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     mode,
   input  logic                                     start,
   input  logic [$clog2(DEPTH+1)-1:0]               count,
   input  logic signed [srch_pkg::VAL_W-1:0]        target,
   output logic [$clog2(DEPTH)-1:0]                 rd_addr,
   input  logic signed [srch_pkg::VAL_W-1:0]        rd_data,
   output srch_pkg::srch_stat_type                  stat,
   output logic signed [$clog2(DEPTH+1):0]          border
);
   import srch_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = CW + 1;

   logic                 active_ff, active_in;
   logic                 phase_ff, phase_in;
   logic                 done_ff, done_in;
   logic                 hit_ff, hit_in;
   logic signed [IW-1:0] left_ff, left_in;
   logic signed [IW-1:0] right_ff, right_in;
   logic signed [IW-1:0] border_ff, border_in;
   logic signed [IW-1:0] mid_ff, mid_in;
   logic signed [IW-1:0] mid_w;
   logic                 step_left;

   // left <= right whenever a read is issued, so the shift sees a non-negative span
   assign mid_w   = left_ff + ((right_ff - left_ff) >>> 1);
   assign rd_addr = mid_w[AW-1:0];

   // below: element >= target moves left; above: element <= target moves right
   assign step_left = (mode == MODE_BELOW) ? (rd_data >= target) : !(rd_data <= target);

   always_comb begin
      active_in = active_ff;
      phase_in  = phase_ff;
      done_in   = done_ff;
      hit_in    = hit_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      border_in = border_ff;
      mid_in    = mid_ff;
      if (start) begin
         active_in = 1'b1;
         phase_in  = 1'b0;
         done_in   = 1'b0;
         hit_in    = 1'b0;
         left_in   = '0;
         right_in  = $signed({1'b0, count}) - IW'(1);
      end else if (active_ff && !phase_ff) begin
         if (left_ff <= right_ff) begin
            mid_in   = mid_w;
            phase_in = 1'b1;
         end else begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end else if (active_ff && phase_ff) begin
         phase_in = 1'b0;
         if (step_left) begin
            right_in = mid_ff - IW'(1);
            if (mode == MODE_BELOW) begin
               border_in = mid_ff - IW'(1);
               hit_in    = 1'b1;
            end
         end else begin
            left_in = mid_ff + IW'(1);
            if (mode == MODE_ABOVE) begin
               border_in = mid_ff + IW'(1);
               hit_in    = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         phase_ff  <= 1'b0;
         done_ff   <= 1'b0;
         hit_ff    <= 1'b0;
      end else begin
         active_ff <= active_in;
         phase_ff  <= phase_in;
         done_ff   <= done_in;
         hit_ff    <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff   <= left_in;
      right_ff  <= right_in;
      border_ff <= border_in;
      mid_ff    <= mid_in;
   end

   assign stat.done = done_ff;
   assign stat.hit  = hit_ff;
   assign border    = border_ff;

`ifndef ASSERT_OFF
   a_done_not_active: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !active_ff)
      else $error("bisection done while still active");
   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      active_ff && !phase_ff && (left_ff <= right_ff) |-> mid_w >= 0)
      else $error("bisection midpoint below zero");
   a_compare_follows_read: assert property (@(posedge clock) disable iff (reset)
      active_ff && phase_ff && !$past(start) |-> $past(active_ff && !phase_ff))
      else $error("compare phase without a preceding read");
`endif

endmodule

[src/sorted_table_equal_range_search_unit.sv]
// ----------------------------------------------------------------------------
// sorted_table_equal_range_search_unit
// equal-range lookup of a signed target in a loaded non-decreasing table
// ----------------------------------------------------------------------------
// usage
//   req channel: action 0 loads value as the next table element (restart 1
//   empties the table first; loads past DEPTH elements are dropped), action 1
//   queries value as a target. loads give no rsp item.
//   rsp channel: one item per query with found, first_index and last_index;
//   not found (or an empty table) answers zero for both indices.
// search
//   a query runs both bisections side by side on the two read ports of the
//   table memory. each step is a read phase plus a compare phase, since the
//   memory's read data is registered.
// reset and stalls
//   reset empties the table (element count to zero) and drops any pending
//   rsp item. the result sits in an output register: a new item is taken
//   while it waits, and a finished query holds until that register is free.
// ----------------------------------------------------------------------------
module sorted_table_equal_range_search_unit #(
   parameter int DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic signed [srch_pkg::VAL_W-1:0]   req_value,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic [srch_pkg::IDX_W-1:0]          rsp_first_index,
   output logic [srch_pkg::IDX_W-1:0]          rsp_last_index
);
   import srch_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = CW + 1;

   // controller states
   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_SEARCH = 1'b1;

   logic                   state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   empty_ff, empty_in;
   logic signed [VAL_W-1:0] target_ff, target_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]       rsp_first_ff, rsp_first_in;
   logic [IDX_W-1:0]       rsp_last_ff, rsp_last_in;

   // handshake and load path
   logic                   req_fire;
   logic                   load_fire;
   logic                   query_fire;
   logic [CW-1:0]          load_base;
   logic                   wr_en;
   logic                   start;

   // engines and memory
   logic [AW-1:0]          rd_addr_lo, rd_addr_hi;
   logic signed [VAL_W-1:0] rd_data_lo, rd_data_hi;
   srch_stat_type          stat_lo, stat_hi;
   logic signed [IW-1:0]   border_lo, border_hi;

   // result assembly
   logic                   result_ready;
   logic                   rsp_free;
   logic                   hit_both;
   logic signed [IW-1:0]   span;
   logic signed [IW-1:0]   first_w, last_w;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign load_fire  = req_fire && (req_action == ACT_LOAD);
   assign query_fire = req_fire && (req_action == ACT_QUERY);

   // restart drops the old table before this element lands at index zero
   assign load_base = req_restart ? '0 : count_ff;
   assign wr_en     = load_fire && (load_base < CW'(DEPTH));

   // an empty table skips the bisections and answers not found
   assign start = query_fire && (count_ff != '0);

   srch_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (load_base[AW-1:0]),
      .wr_data   (req_value),
      .rd_addr_a (rd_addr_lo),
      .rd_data_a (rd_data_lo),
      .rd_addr_b (rd_addr_hi),
      .rd_data_b (rd_data_hi)
   );

   // last position below the target
   srch_bisect #(
      .DEPTH (DEPTH)
   ) u_below (
      .clock   (clock),
      .reset   (reset),
      .mode    (MODE_BELOW),
      .start   (start),
      .count   (count_ff),
      .target  (target_ff),
      .rd_addr (rd_addr_lo),
      .rd_data (rd_data_lo),
      .stat    (stat_lo),
      .border  (border_lo)
   );

   // first position above the target
   srch_bisect #(
      .DEPTH (DEPTH)
   ) u_above (
      .clock   (clock),
      .reset   (reset),
      .mode    (MODE_ABOVE),
      .start   (start),
      .count   (count_ff),
      .target  (target_ff),
      .rd_addr (rd_addr_hi),
      .rd_data (rd_data_hi),
      .stat    (stat_hi),
      .border  (border_hi)
   );

   // both engines compare against the target held since the query

   assign result_ready = empty_ff || (stat_lo.done && stat_hi.done);
   assign rsp_free     = !rsp_valid_ff || rsp_ready;

   // a range exists only when both borders were set and enclose at least one slot
   assign hit_both = stat_lo.hit && stat_hi.hit;
   assign span     = border_hi - border_lo;
   assign first_w  = border_lo + IW'(1);
   assign last_w   = border_hi - IW'(1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      empty_in     = empty_ff;
      target_in    = target_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_first_in = rsp_first_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (wr_en) begin
               count_in = load_base + CW'(1);
            end else if (load_fire) begin
               count_in = load_base;
            end
            if (query_fire) begin
               target_in = req_value;
               empty_in  = (count_ff == '0);
               state_in  = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (result_ready && rsp_free) begin
               rsp_valid_in = 1'b1;
               if (!empty_ff && hit_both && (span > IW'(1))) begin
                  rsp_found_in = 1'b1;
                  rsp_first_in = IDX_W'($unsigned(first_w));
                  rsp_last_in  = IDX_W'($unsigned(last_w));
               end else begin
                  rsp_found_in = 1'b0;
                  rsp_first_in = '0;
                  rsp_last_in  = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         empty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff    <= target_in;
      rsp_found_ff <= rsp_found_in;
      rsp_first_ff <= rsp_first_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_first_index = rsp_first_ff;
   assign rsp_last_index  = rsp_last_ff;

`ifndef ASSERT_OFF
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("element count beyond table depth");
   a_load_appends: assert property (@(posedge clock) disable iff (reset)
      load_fire && !req_restart && (count_ff < CW'(DEPTH)) |=>
      count_ff == $past(count_ff) + CW'(1))
      else $error("load did not append one element");
   a_query_enters_search: assert property (@(posedge clock) disable iff (reset)
      query_fire |=> state_ff == ST_SEARCH)
      else $error("query accepted without starting a search");
   a_rsp_from_search: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_SEARCH))
      else $error("result item raised outside a search");
   a_miss_zero_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_first_ff == '0 && rsp_last_ff == '0)
      else $error("not-found item carries nonzero indices");
`endif

endmodule
